[sv/sacl_pkg.sv]
// shared types and constants for the set-associative lru cache
// no dependencies; used by sacl_ctrl, sacl_datapath and the top level
package sacl_pkg;

   localparam int ADDR_W      = 14;
   localparam int WORD_ADDR_W = 12;
   localparam int DATA_W      = 32;
   localparam int STAMP_W     = 32;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic CSR_WRITE_ALLOCATE = 1'b0;
   localparam logic CSR_WRITE_BACK     = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              hit;
      logic              evicted_dirty;
      logic              memory_written;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LK_RD,
      ST_LK_CHK,
      ST_MISS,
      ST_WB_RD,
      ST_WB_WR,
      ST_FL_RD,
      ST_FL_WR,
      ST_ACCESS,
      ST_RD_WAIT,
      ST_BYPASS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic latch_req;
      logic way_check;
      logic slot_take;
      logic wb_wr;
      logic fill_rd;
      logic fill_wr;
      logic access;
      logic rd_capture;
      logic bypass;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hit_now;
      logic way_last;
      logic word_last;
      logic is_write;
      logic alloc;
      logic need_wb;
   } stat_type;

endpackage

[sv/sacl_ram.sv]
// generic single-port ram with registered read
// no dependencies
module sacl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                      wdata,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/sacl_ctrl.sv]
// controller state machine of the cache
// depends on sacl_pkg
module sacl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sacl_pkg::stat_type  stat,
   output sacl_pkg::cmd_type   cmd,
   output logic                busy
);
   import sacl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (start) state_in = ST_LK_RD;
         ST_LK_RD:   state_in = ST_LK_CHK;
         ST_LK_CHK: begin
            if (stat.hit_now) state_in = ST_ACCESS;
            else if (stat.way_last) state_in = ST_MISS;
            else state_in = ST_LK_RD;
         end
         ST_MISS: begin
            if (stat.is_write && !stat.alloc) state_in = ST_BYPASS;
            else if (stat.need_wb) state_in = ST_WB_RD;
            else state_in = ST_FL_RD;
         end
         ST_WB_RD:   state_in = ST_WB_WR;
         ST_WB_WR:   state_in = stat.word_last ? ST_FL_RD : ST_WB_RD;
         ST_FL_RD:   state_in = ST_FL_WR;
         ST_FL_WR:   state_in = stat.word_last ? ST_ACCESS : ST_FL_RD;
         ST_ACCESS:  state_in = stat.is_write ? ST_DONE : ST_RD_WAIT;
         ST_RD_WAIT: state_in = ST_DONE;
         ST_BYPASS:  state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // lookup and writeback read states only present ram addresses, no command
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:   cmd.clr_step = 1'b1;
         ST_IDLE:    cmd.latch_req = start;
         ST_LK_CHK:  cmd.way_check = 1'b1;
         ST_MISS:    cmd.slot_take = 1'b1;
         ST_WB_WR:   cmd.wb_wr = 1'b1;
         ST_FL_RD:   cmd.fill_rd = 1'b1;
         ST_FL_WR:   cmd.fill_wr = 1'b1;
         ST_ACCESS:  cmd.access = 1'b1;
         ST_RD_WAIT: cmd.rd_capture = 1'b1;
         ST_BYPASS:  cmd.bypass = 1'b1;
         ST_DONE:    cmd.respond = 1'b1;
         default:    cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

[sv/sacl_datapath.sv]
// datapath: request and victim registers, metadata, line data and backing memory
// depends on sacl_pkg and sacl_ram
module sacl_datapath #(
   parameter int NUM_SETS       = 16,
   parameter int NUM_WAYS       = 4,
   parameter int WORDS_PER_LINE = 8,
   parameter int MEMORY_WORDS   = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sacl_pkg::req_item_type req_item,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic                   csr_wdata,
   input  sacl_pkg::cmd_type      cmd,
   output sacl_pkg::stat_type     stat,
   output logic                   rsp_valid,
   output sacl_pkg::rsp_item_type rsp_item
);
   import sacl_pkg::*;

   localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
   localparam int OFF_BITS  = $clog2(WORDS_PER_LINE);
   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int WAY_W     = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
   localparam int WORD_W    = WORDS_PER_LINE > 1 ? $clog2(WORDS_PER_LINE) : 1;
   localparam int LINE_W    = NUM_LINES > 1 ? $clog2(NUM_LINES) : 1;
   localparam int DATA_DEPTH = NUM_LINES * WORDS_PER_LINE;
   localparam int DADDR_W   = DATA_DEPTH > 1 ? $clog2(DATA_DEPTH) : 1;
   localparam int MEM_W     = $clog2(MEMORY_WORDS);
   localparam int META_W    = WORD_ADDR_W + STAMP_W;

   req_item_type             req_ff;
   logic [WAY_W-1:0]         way_ff, vway_ff;
   logic [WORD_W-1:0]        word_ff;
   logic [LINE_W-1:0]        slot_ff;
   logic [WORD_ADDR_W-1:0]   vtag_ff;
   logic [STAMP_W-1:0]       vstamp_ff, use_cnt_ff;
   logic                     inv_found_ff, hit_ff, evict_ff, memw_ff;
   logic [DATA_W-1:0]        rdata_ff;
   logic [NUM_LINES-1:0]     valid_ff, dirty_ff;
   logic [MEM_W-1:0]         clr_addr_ff;
   logic                     alloc_ff, wb_ff;
   logic                     rsp_valid_ff;
   rsp_item_type             rsp_ff;

   // address split
   logic [WORD_ADDR_W-1:0] word_addr, line_no, req_tag;
   logic [31:0]            set_idx, offset, cur_line, vic_line, wb_base, fill_base;
   logic [31:0]            data_addr_w, mem_addr_w, meta_addr_w;
   logic [LINE_W-1:0]      cur_slot;

   assign word_addr = req_ff.address[ADDR_W-1:2];
   assign line_no   = word_addr >> OFF_BITS;
   assign req_tag   = line_no >> SET_BITS;
   assign set_idx   = 32'(line_no) & 32'(NUM_SETS - 1);
   assign offset    = 32'(word_addr) & 32'(WORDS_PER_LINE - 1);
   assign cur_line  = set_idx * 32'(NUM_WAYS) + 32'(way_ff);
   assign vic_line  = set_idx * 32'(NUM_WAYS) + 32'(vway_ff);
   assign cur_slot  = cur_line[LINE_W-1:0];
   assign wb_base   = ((32'(vtag_ff) << SET_BITS) | set_idx) << OFF_BITS;
   assign fill_base = 32'(line_no) << OFF_BITS;

   // metadata ram: tag and use stamp per line
   logic              meta_we;
   logic [META_W-1:0] meta_wdata, meta_rdata;
   logic [WORD_ADDR_W-1:0] meta_tag;
   logic [STAMP_W-1:0]     meta_stamp;

   assign meta_we     = cmd.access;
   assign meta_wdata  = {req_tag, use_cnt_ff + 32'd1};
   assign meta_addr_w = cmd.access ? 32'(slot_ff) : cur_line;
   assign meta_tag    = meta_rdata[META_W-1:STAMP_W];
   assign meta_stamp  = meta_rdata[STAMP_W-1:0];

   sacl_ram #(.WIDTH(META_W), .DEPTH(NUM_LINES)) u_meta (
      .clock (clock),
      .we    (meta_we),
      .addr  (meta_addr_w[LINE_W-1:0]),
      .wdata (meta_wdata),
      .rdata (meta_rdata)
   );

   // line data ram
   logic              data_we;
   logic [DATA_W-1:0] data_wdata, data_rdata, mem_rdata;

   assign data_we     = cmd.fill_wr || (cmd.access && req_ff.req_type == REQ_WRITE);
   assign data_wdata  = cmd.fill_wr ? mem_rdata : req_ff.write_data;
   assign data_addr_w = (32'(slot_ff) << OFF_BITS) + (cmd.access ? offset : 32'(word_ff));

   sacl_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data (
      .clock (clock),
      .we    (data_we),
      .addr  (data_addr_w[DADDR_W-1:0]),
      .wdata (data_wdata),
      .rdata (data_rdata)
   );

   // backing memory
   logic              mem_we;
   logic [DATA_W-1:0] mem_wdata;

   assign mem_we = cmd.clr_step || cmd.wb_wr || cmd.bypass
                || (cmd.access && req_ff.req_type == REQ_WRITE && !wb_ff);

   always_comb begin
      if (cmd.clr_step) begin
         mem_addr_w = 32'(clr_addr_ff);
         mem_wdata  = '0;
      end else if (cmd.wb_wr) begin
         mem_addr_w = wb_base + 32'(word_ff);
         mem_wdata  = data_rdata;
      end else if (cmd.fill_rd) begin
         mem_addr_w = fill_base + 32'(word_ff);
         mem_wdata  = req_ff.write_data;
      end else begin
         mem_addr_w = 32'(word_addr);
         mem_wdata  = req_ff.write_data;
      end
   end

   sacl_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr_w[MEM_W-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // status
   logic hit_now, word_last;
   assign hit_now   = valid_ff[cur_slot] && (meta_tag == req_tag);
   assign word_last = (word_ff == WORD_W'(WORDS_PER_LINE - 1));

   always_comb begin
      stat.clear_done = (clr_addr_ff == MEM_W'(MEMORY_WORDS - 1));
      stat.hit_now    = hit_now;
      stat.way_last   = (way_ff == WAY_W'(NUM_WAYS - 1));
      stat.word_last  = word_last;
      stat.is_write   = (req_ff.req_type == REQ_WRITE);
      stat.alloc      = alloc_ff;
      stat.need_wb    = !inv_found_ff && dirty_ff[vic_line[LINE_W-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= 1'b1;
         wb_ff        <= 1'b1;
         clr_addr_ff  <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         use_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_WRITE_ALLOCATE) alloc_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_WRITE_BACK) wb_ff <= csr_wdata;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + MEM_W'(1);
         if (cmd.fill_wr && word_last) begin
            valid_ff[slot_ff] <= 1'b1;
            dirty_ff[slot_ff] <= 1'b0;
         end
         if (cmd.access) begin
            use_cnt_ff <= use_cnt_ff + 32'd1;
            if (req_ff.req_type == REQ_WRITE && wb_ff) dirty_ff[slot_ff] <= 1'b1;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff       <= req_item;
         way_ff       <= '0;
         hit_ff       <= 1'b0;
         evict_ff     <= 1'b0;
         memw_ff      <= 1'b0;
         inv_found_ff <= 1'b0;
         rdata_ff     <= '0;
      end
      if (cmd.way_check) begin
         way_ff <= way_ff + WAY_W'(1);
         if (hit_now) begin
            hit_ff  <= 1'b1;
            slot_ff <= cur_slot;
         end
         // first invalid way wins, else lowest stamp with ties to the higher way
         if (!inv_found_ff) begin
            if (!valid_ff[cur_slot]) begin
               inv_found_ff <= 1'b1;
               vway_ff      <= way_ff;
            end else if (way_ff == '0 || meta_stamp <= vstamp_ff) begin
               vway_ff   <= way_ff;
               vstamp_ff <= meta_stamp;
               vtag_ff   <= meta_tag;
            end
         end
      end
      if (cmd.slot_take) begin
         slot_ff <= vic_line[LINE_W-1:0];
         word_ff <= '0;
      end
      if (cmd.wb_wr || cmd.fill_wr) begin
         word_ff <= word_last ? '0 : word_ff + WORD_W'(1);
      end
      if (cmd.wb_wr) evict_ff <= 1'b1;
      if (cmd.bypass) memw_ff <= 1'b1;
      if (cmd.access && req_ff.req_type == REQ_WRITE && !wb_ff) memw_ff <= 1'b1;
      if (cmd.rd_capture) rdata_ff <= data_rdata;
      if (cmd.respond) begin
         rsp_ff.read_data      <= rdata_ff;
         rsp_ff.hit            <= hit_ff;
         rsp_ff.evicted_dirty  <= evict_ff;
         rsp_ff.memory_written <= memw_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

[sv/set_assoc_cache_lru.sv]
// top level of the set-associative cache, write-back or write-through by csr, with lru replacement
// depends on sacl_pkg, sacl_ctrl, sacl_datapath (and sacl_ram below it)
//
//   channel   ports                          handshake
//   request   req_item                       start & !busy
//   response  rsp_item                       rsp_valid, one cycle, no stall
//   csr       csr_index, csr_wdata           csr_we
//
// per request: each way probed up to the hit takes a read and a check; a
// hit read passes access, read wait and done, a hit write access and done;
// a miss probes all ways and picks the victim; a write miss with allocation
// off then needs bypass and done, otherwise a dirty victim is written back
// and the line refilled word by word, ending as a hit; the response strobe is
// registered from done; the single-port backing memory sets the miss cost
// after reset busy stays high while the backing memory is cleared; csr
// writes are taken during that pass
// one request at a time; the receiver cannot stall responses
module set_assoc_cache_lru #(
   parameter int NUM_SETS       = 16,
   parameter int NUM_WAYS       = 4,
   parameter int WORDS_PER_LINE = 8,
   parameter int MEMORY_WORDS   = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sacl_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output sacl_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic                   csr_wdata
);
   import sacl_pkg::*;

   // command and status between controller and datapath
   cmd_type  cmd;
   stat_type stat;

   sacl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   sacl_datapath #(
      .NUM_SETS       (NUM_SETS),
      .NUM_WAYS       (NUM_WAYS),
      .WORDS_PER_LINE (WORDS_PER_LINE),
      .MEMORY_WORDS   (MEMORY_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );
endmodule
